FILE: rtl/core/tccw_pkg.sv
`default_nettype none
package tccw_pkg;

  localparam int ACTION_W  = 2;
  localparam int CHAR_W    = 8;
  localparam int INDEX_W   = 11;
  localparam int ATTR_W    = 8;
  localparam int CELL_W    = 16;
  localparam int COL_OUT_W = 7;
  localparam int ROW_OUT_W = 5;
  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 32;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TILDE = 8'h7E;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0020;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUT   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    FILL_ZERO,
    FILL_ATTR,
    FILL_SCROLL
  } fill_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_PUT,
    ST_CLEAR,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic  load_item;
    logic  start_scroll;
    logic  start_clear;
    logic  sweep_step;
    fill_t fill;
    logic  issue_read;
    logic  capture_read;
    logic  apply_put;
    logic  load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    action_t action;
    logic    need_scroll;
    logic    read_ok;
    logic    sweep_last;
    logic    out_free;
  } dp_status_t;

endpackage
`default_nettype wire

FILE: rtl/core/tccw_ram.sv
`default_nettype none
module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/tccw_ctrl.sv
`default_nettype none
module tccw_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output      logic                s_tready,
  output      tccw_pkg::ctrl_cmd_t cmd,
  input  wire tccw_pkg::dp_status_t status
);

  import tccw_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.fill   = FILL_ZERO;
    s_tready   = 1'b0;
    case (state)
      ST_INIT: begin
        cmd.sweep_step = 1'b1;
        cmd.fill       = FILL_ZERO;
        if (status.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (status.action)
          ACT_PUT: begin
            if (status.need_scroll) begin
              cmd.start_scroll = 1'b1;
              state_next       = ST_SCROLL;
            end else begin
              cmd.apply_put = 1'b1;
              state_next    = ST_DONE;
            end
          end
          ACT_CLEAR: begin
            cmd.start_clear = 1'b1;
            state_next      = ST_CLEAR;
          end
          ACT_READ: begin
            if (status.read_ok) begin
              cmd.issue_read = 1'b1;
              state_next     = ST_READ;
            end else begin
              state_next = ST_DONE;
            end
          end
          default: begin
            state_next = ST_DONE;
          end
        endcase
      end
      ST_SCROLL: begin
        cmd.sweep_step = 1'b1;
        cmd.fill       = FILL_SCROLL;
        if (status.sweep_last) begin
          state_next = ST_PUT;
        end
      end
      ST_PUT: begin
        cmd.apply_put = 1'b1;
        state_next    = ST_DONE;
      end
      ST_CLEAR: begin
        cmd.sweep_step = 1'b1;
        cmd.fill       = FILL_ATTR;
        if (status.sweep_last) begin
          state_next = ST_DONE;
        end
      end
      ST_READ: begin
        cmd.capture_read = 1'b1;
        state_next       = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/tccw_datapath.sv
`default_nettype none
module tccw_datapath #(
  parameter int COLUMNS = 80,
  parameter int LINES   = 25
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire tccw_pkg::ctrl_cmd_t                   cmd,
  output      tccw_pkg::dp_status_t                  status,
  input  wire logic [tccw_pkg::S_TDATA_W-1:0]        s_tdata,
  input  wire logic [tccw_pkg::ACTION_W-1:0]         s_tuser,
  input  wire logic                                  cfg_valid,
  input  wire logic [tccw_pkg::ATTR_W-1:0]           cfg_data,
  output      logic                                  m_tvalid,
  input  wire logic                                  m_tready,
  output      logic [tccw_pkg::M_TDATA_W-1:0]        m_tdata
);

  import tccw_pkg::*;

  localparam int CELLS = COLUMNS * LINES;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int LW    = $clog2(LINES + 1);

  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] COPY_END  = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
  localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
  localparam logic [LW-1:0] LINES_L   = LW'(LINES);

  action_t              action;
  logic [CHAR_W-1:0]    char_code;
  logic [INDEX_W-1:0]   cell_index;
  logic [ATTR_W-1:0]    attr;
  logic [CW-1:0]        col;
  logic [LW-1:0]        line;
  logic [AW-1:0]        cnt;
  logic                 scrolled;
  logic [CELL_W-1:0]    cell_data;

  // writes go out in the cycle after they are set up, so a scroll copy can
  // take its data straight from the read port
  logic                 wr_pend;
  logic [AW-1:0]        wr_addr;
  logic                 wr_copy;
  logic [CELL_W-1:0]    wr_value;

  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [CELL_W-1:0]    rd_data;

  logic                 copy_cell;
  logic                 printable;
  logic [AW-1:0]        put_pos;
  logic [CELL_W-1:0]    fill_value;

  assign copy_cell = (cmd.fill == FILL_SCROLL) && (cnt < COPY_END);
  assign printable = (char_code >= CH_SPACE) && (char_code <= CH_TILDE);
  assign put_pos   = AW'(AW'(line) * COLS_A) + AW'(col);

  always_comb begin
    case (cmd.fill)
      FILL_ZERO: fill_value = '0;
      FILL_ATTR: fill_value = {attr, CH_SPACE};
      default:   fill_value = BLANK_CELL;
    endcase
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = AW'(cell_index);
    if (cmd.issue_read) begin
      rd_en = 1'b1;
    end else if (cmd.sweep_step && copy_cell) begin
      rd_en   = 1'b1;
      rd_addr = cnt + COLS_A;
    end
  end

  tccw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_pend),
    .wr_addr (wr_addr),
    .wr_data (wr_copy ? rd_data : wr_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      attr     <= ATTR_RESET;
      col      <= '0;
      line     <= '0;
      cnt      <= '0;
      wr_pend  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        attr <= cfg_data;
      end
      wr_pend <= cmd.sweep_step || (cmd.apply_put && printable);
      if (cmd.sweep_step) begin
        cnt <= cnt + 1'b1;
      end
      if (cmd.start_scroll) begin
        line <= line - 1'b1;
        cnt  <= '0;
      end
      if (cmd.start_clear) begin
        col  <= '0;
        line <= '0;
        cnt  <= '0;
      end
      if (cmd.apply_put) begin
        if (char_code == CH_LF) begin
          col  <= '0;
          line <= line + 1'b1;
        end else if (char_code == CH_CR) begin
          col <= '0;
        end else if (printable) begin
          if (col == LAST_COL) begin
            col  <= '0;
            line <= line + 1'b1;
          end else begin
            col <= col + 1'b1;
          end
        end
      end
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      action     <= action_t'(s_tuser);
      char_code  <= s_tdata[CHAR_W-1:0];
      cell_index <= s_tdata[CHAR_W +: INDEX_W];
      scrolled   <= 1'b0;
      cell_data  <= '0;
    end
    if (cmd.start_scroll) begin
      scrolled <= 1'b1;
    end
    if (cmd.capture_read) begin
      cell_data <= rd_data;
    end
    if (cmd.sweep_step) begin
      wr_addr  <= cnt;
      wr_copy  <= copy_cell;
      wr_value <= fill_value;
    end else if (cmd.apply_put) begin
      wr_addr  <= put_pos;
      wr_copy  <= 1'b0;
      wr_value <= {attr, char_code};
    end
    if (cmd.load_out) begin
      m_tdata <= {3'b000, scrolled, cell_data, ROW_OUT_W'(line), COL_OUT_W'(col)};
    end
  end

  assign status.action      = action;
  assign status.need_scroll = (char_code != CH_NUL) && (line >= LINES_L);
  assign status.read_ok     = 32'(cell_index) < 32'(CELLS);
  assign status.sweep_last  = (cnt == LAST_CELL);
  assign status.out_free    = !m_tvalid || m_tready;

endmodule
`default_nettype wire

FILE: rtl/core/text_console_char_writer.sv
`default_nettype none
// Text-mode console writer holding a LINES x COLUMNS grid of 16-bit cells (attribute in
// the high byte, character in the low byte) and a cursor. Each request (put character,
// clear screen, read cell) returns one result with the cursor, the cell read and a
// scroll flag. After reset the block clears its cell memory in one pass before taking
// requests. A clear and a put that scrolls sweep the whole cell memory one cell a cycle,
// while a plain put, a read of a cell in range and an ignored request do not. One request
// is processed at a time; a finished result waits in the output register while the next
// request is taken. The attribute register may be written only when idle.
module text_console_char_writer #(
  parameter int COLUMNS = 80,
  parameter int LINES   = 25
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output      logic                              s_tready,
  // char_code [7:0], cell_index [18:8]
  input  wire logic [tccw_pkg::S_TDATA_W-1:0]    s_tdata,
  // action [1:0]
  input  wire logic [tccw_pkg::ACTION_W-1:0]     s_tuser,
  output      logic                              m_tvalid,
  input  wire logic                              m_tready,
  // cursor_col [6:0], cursor_row [11:7], cell_data [27:12], scrolled [28]
  output      logic [tccw_pkg::M_TDATA_W-1:0]    m_tdata,
  input  wire logic                              cfg_valid,
  output      logic                              cfg_ready,
  input  wire logic [tccw_pkg::ATTR_W-1:0]       cfg_data
);

  import tccw_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  tccw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .status   (status)
  );

  tccw_datapath #(
    .COLUMNS (COLUMNS),
    .LINES   (LINES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
`default_nettype wire
